>>> src/skvt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package skvt_pkg;

  localparam int unsigned CapacityDefault = 16;

  // Operation codes of an input item
  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_LOOKUP = 3'd2;
  localparam logic [2:0] OP_CLEAR  = 3'd3;
  localparam logic [2:0] OP_DUMP   = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  // Cell command codes, broadcast along the chain
  localparam logic [2:0] CM_HOLD = 3'd0;
  localparam logic [2:0] CM_CMP  = 3'd1;
  localparam logic [2:0] CM_INS  = 3'd2;
  localparam logic [2:0] CM_UPD  = 3'd3;
  localparam logic [2:0] CM_DEL  = 3'd4;
  localparam logic [2:0] CM_ROT  = 3'd5;
  localparam logic [2:0] CM_CLR  = 3'd6;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] key;
    logic [7:0]  value;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       found;
    logic [7:0] value_out;
    logic [4:0] entry_count;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] key;
    logic [7:0]  value;
  } cell_ctrl_t;

  // What one cell shows its neighbors
  typedef struct packed {
    logic        valid;
    logic        lt;
    logic [31:0] key;
    logic [7:0]  value;
  } cell_link_t;

endpackage

`default_nettype wire

>>> src/skvt_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module skvt_cell
  import skvt_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  cell_link_t left_i,
  input  cell_link_t right_i,
  input  cell_link_t head_i,
  output cell_link_t link_o,
  output logic       eq_o
);

  logic        valid_q, valid_d;
  logic        lt_q, lt_d;
  logic        eq_q, eq_d;
  logic [31:0] key_q, key_d;
  logic [7:0]  value_q, value_d;

  always_comb begin
    valid_d = valid_q;
    lt_d    = lt_q;
    eq_d    = eq_q;
    key_d   = key_q;
    value_d = value_q;
    case (ctrl_i.mode)
      CM_CMP: begin
        lt_d = valid_q && (key_q < ctrl_i.key);
        eq_d = valid_q && (key_q == ctrl_i.key);
      end
      CM_INS: begin
        // first cell not below the key takes the new entry, the rest shift right
        if (!lt_q) begin
          if (left_i.lt) begin
            valid_d = 1'b1;
            key_d   = ctrl_i.key;
            value_d = ctrl_i.value;
          end else begin
            valid_d = left_i.valid;
            key_d   = left_i.key;
            value_d = left_i.value;
          end
        end
      end
      CM_UPD: begin
        if (eq_q) begin
          value_d = ctrl_i.value;
        end
      end
      CM_DEL: begin
        if (!lt_q) begin
          valid_d = right_i.valid;
          key_d   = right_i.key;
          value_d = right_i.value;
        end
      end
      CM_ROT: begin
        // rotate the occupied cells left by one, the tail takes the head
        if (valid_q) begin
          if (right_i.valid) begin
            key_d   = right_i.key;
            value_d = right_i.value;
          end else begin
            key_d   = head_i.key;
            value_d = head_i.value;
          end
        end
      end
      CM_CLR: begin
        valid_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      lt_q    <= 1'b0;
      eq_q    <= 1'b0;
    end else begin
      valid_q <= valid_d;
      lt_q    <= lt_d;
      eq_q    <= eq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
  end

  assign link_o = '{valid: valid_q, lt: lt_q, key: key_q, value: value_q};
  assign eq_o   = eq_q;

endmodule

`default_nettype wire

>>> src/sorted_key_value_table_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Sorted key/value table: up to CAPACITY unique 32-bit keys with byte values,
// held in ascending key order in a chain of cells. Pulse start with an item
// while busy is low; every result appears for exactly one cycle with
// result_valid_o high and must be taken then, since the block cannot be held
// off. Insert, remove, lookup, clear and unused codes give one result: every
// cell compares its key to the item key in parallel and registers the outcome
// on the accept edge, the chain shifts or updates in the next cycle while the
// result register loads, and the result shows from that register. busy is
// high for the single cycle in between, so a new item may be accepted in the
// cycle the result is shown and not before. A dump of N entries rotates the
// occupied cells left once per cycle, reading the head cell, so it shows its N
// results on consecutive cycles after its execute cycle and keeps busy high
// until the last result is registered; the rotation leaves the table as it
// found it. A dump of an empty table gives one result like the other
// operations. No clearing pass follows reset.

module sorted_key_value_table_core
  import skvt_pkg::*;
#(
  parameter int unsigned CAPACITY = CapacityDefault
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       start,
  output logic      busy,
  input  in_item_t  item_i,
  output logic      result_valid_o,
  output out_item_t result_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = $clog2(CAPACITY);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DUMP = 2'd2;

  logic [1:0]    state_q, state_d;
  in_item_t      cmd_q;
  logic [CW-1:0] count_q, count_d;
  logic [IW-1:0] dump_idx_q, dump_idx_d;
  logic          res_valid_q, res_valid_d;
  out_item_t     res_q, res_d;

  cell_ctrl_t    ctrl;
  cell_link_t    links [CAPACITY];
  cell_link_t    left_links [CAPACITY];
  cell_link_t    right_links [CAPACITY];
  logic [CAPACITY-1:0] eq_vec;
  logic [CAPACITY-1:0] valid_vec;

  logic          accept;
  logic          hit;
  logic [7:0]    hit_value;
  logic          full;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);
  assign full   = (count_q == CW'(CAPACITY));

  // Build the chain; the left edge looks like a cell below every key,
  // the right edge like an empty cell.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_links[i] = '{valid: 1'b0, lt: 1'b1, key: '0, value: '0};
    end else begin : g_mid
      assign left_links[i] = links[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_links[i] = '{valid: 1'b0, lt: 1'b0, key: '0, value: '0};
    end else begin : g_inner
      assign right_links[i] = links[i+1];
    end

    skvt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .left_i  (left_links[i]),
      .right_i (right_links[i]),
      .head_i  (links[0]),
      .link_o  (links[i]),
      .eq_o    (eq_vec[i])
    );

    assign valid_vec[i] = links[i].valid;
  end

  // At most one cell matches: merge its value with an AND-OR over the row.
  always_comb begin
    hit_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_value = hit_value | ({8{eq_vec[i]}} & links[i].value);
    end
  end
  assign hit = |eq_vec;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    dump_idx_d  = dump_idx_q;
    res_valid_d = 1'b0;
    res_d       = '{status: ST_OK, found: 1'b0, value_out: '0,
                    entry_count: '0, last: 1'b1};
    ctrl        = '{mode: CM_HOLD, key: cmd_q.key, value: cmd_q.value};

    case (state_q)
      S_IDLE: begin
        // compare against the incoming key on the accept edge
        if (accept) begin
          ctrl.mode = CM_CMP;
          ctrl.key  = item_i.key;
          state_d   = S_EXEC;
        end
      end
      S_EXEC: begin
        res_valid_d = 1'b1;
        state_d     = S_IDLE;
        case (cmd_q.operation)
          OP_INSERT: begin
            if (hit) begin
              ctrl.mode   = CM_UPD;
              res_d.found = 1'b1;
            end else if (full) begin
              res_d.status = ST_FULL;
            end else begin
              ctrl.mode = CM_INS;
              count_d   = count_q + 1'b1;
            end
          end
          OP_REMOVE: begin
            if (hit) begin
              ctrl.mode   = CM_DEL;
              res_d.found = 1'b1;
              count_d     = count_q - 1'b1;
            end else begin
              res_d.status = ST_NOT_FOUND;
            end
          end
          OP_LOOKUP: begin
            if (hit) begin
              res_d.found     = 1'b1;
              res_d.value_out = hit_value;
            end else begin
              res_d.status = ST_NOT_FOUND;
            end
          end
          OP_CLEAR: begin
            ctrl.mode = CM_CLR;
            count_d   = '0;
          end
          OP_DUMP: begin
            // an empty table answers at once, otherwise start the rotation
            if (count_q != '0) begin
              res_valid_d = 1'b0;
              dump_idx_d  = '0;
              state_d     = S_DUMP;
            end
          end
          default: begin
          end
        endcase
      end
      S_DUMP: begin
        ctrl.mode       = CM_ROT;
        res_valid_d     = 1'b1;
        res_d.value_out = links[0].value;
        res_d.last      = (CW'(dump_idx_q) + 1'b1 == count_q);
        dump_idx_d      = dump_idx_q + 1'b1;
        if (res_d.last) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    res_d.entry_count = 5'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      dump_idx_q  <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      dump_idx_q  <= dump_idx_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Hold the item for the execute cycle; load the result register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= item_i;
    end
    res_q <= res_d;
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  // The occupied cells always form a prefix of the chain of length count.
  a_valid_prefix : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($countones(valid_vec) == count_q) && ((valid_vec & (valid_vec + 1'b1)) == '0))
    else $error("occupied cells do not match the entry count");

  // An execute cycle for anything but a non-empty dump yields a result.
  a_exec_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && !(cmd_q.operation == OP_DUMP && count_q != '0))
      |=> result_valid_o)
    else $error("execute cycle without a result");

  // A dump step ending the dump returns to idle and marks its result last.
  a_dump_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DUMP && state_d == S_IDLE) |=> (result_valid_o && result_o.last))
    else $error("dump ended without a last result");

  // The count never exceeds the chain length.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

endmodule

`default_nettype wire

>>> dv/sorted_key_value_table_core_tb.sv
`timescale 1ns / 1ps

// Testbench for sorted_key_value_table_core.
//
// Items go in through the start/busy handshake, driven on the falling edge.
// Every accepted item runs through a local copy of the table, which queues
// the results that item must produce. A monitor on the rising edge pops one
// expected result per strobe and compares every field.
module sorted_key_value_table_core_tb;
  import skvt_pkg::*;

  localparam int unsigned TableDepth = CapacityDefault;
  localparam int unsigned KeyPoolSize = 24;
  localparam int unsigned MaxReported = 10;

  // Operation codes the block does not define; it must answer them with a
  // plain ok result and leave the table alone.
  localparam logic [2:0] OP_UNUSED_A = 3'd5;
  localparam logic [2:0] OP_UNUSED_B = 3'd6;
  localparam logic [2:0] OP_UNUSED_C = 3'd7;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  item_i = '0;
  logic      result_valid_o;
  out_item_t result_o;

  // Local copy of the table, updated as each item is accepted
  logic [31:0] table_keys [TableDepth];
  logic [7:0]  table_values [TableDepth];
  int unsigned table_count = 0;

  // Results the table must still show, oldest first
  out_item_t   pending_results [$];
  int unsigned mismatch_count = 0;

  // Keys drawn most of the time, so that inserts, removes and lookups hit
  logic [31:0] key_pool [KeyPoolSize];

  sorted_key_value_table_core #(
    .CAPACITY(TableDepth)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  always #1 clk_i = ~clk_i;

  // Apply one item to the local table and queue the results it causes.
  function automatic void apply_table_op(in_item_t it);
    int unsigned pos;
    int unsigned i;
    bit          hit;
    out_item_t   r;
    pos = 0;
    while (pos < table_count && table_keys[pos] < it.key) pos++;
    hit = (pos < table_count) && (table_keys[pos] == it.key);
    r = '0;
    r.status = ST_OK;
    r.last = 1'b1;
    case (it.operation)
      OP_INSERT: begin
        if (hit) begin
          table_values[pos] = it.value;
          r.found = 1'b1;
        end else if (table_count >= TableDepth) begin
          r.status = ST_FULL;
        end else begin
          // open a slot at the sorted position
          for (i = table_count; i > pos; i--) begin
            table_keys[i] = table_keys[i - 1];
            table_values[i] = table_values[i - 1];
          end
          table_keys[pos] = it.key;
          table_values[pos] = it.value;
          table_count++;
        end
      end
      OP_REMOVE: begin
        if (hit) begin
          for (i = pos; i + 1 < table_count; i++) begin
            table_keys[i] = table_keys[i + 1];
            table_values[i] = table_values[i + 1];
          end
          table_count--;
          r.found = 1'b1;
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      OP_LOOKUP: begin
        if (hit) begin
          r.found = 1'b1;
          r.value_out = table_values[pos];
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      OP_CLEAR: begin
        table_count = 0;
      end
      OP_DUMP: begin
        // one result per entry in key order; an empty table still answers once
        if (table_count != 0) begin
          for (i = 0; i < table_count; i++) begin
            r.value_out = table_values[i];
            r.entry_count = table_count[4:0];
            r.last = (i + 1 == table_count);
            pending_results.push_back(r);
          end
          return;
        end
      end
      default: begin
      end
    endcase
    r.entry_count = table_count[4:0];
    pending_results.push_back(r);
  endfunction

  function automatic in_item_t make_item(logic [2:0] op, logic [31:0] key,
                                         logic [7:0] value);
    in_item_t it;
    it.operation = op;
    it.key = key;
    it.value = value;
    return it;
  endfunction

  // Draw a random item: mostly table traffic on pooled keys, some noise.
  function automatic in_item_t random_table_item();
    in_item_t    it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) it.operation = OP_INSERT;
    else if (pick < 60) it.operation = OP_REMOVE;
    else if (pick < 84) it.operation = OP_LOOKUP;
    else if (pick < 92) it.operation = OP_DUMP;
    else if (pick < 95) it.operation = OP_CLEAR;
    else it.operation = OP_UNUSED_A + 3'($urandom_range(0, 2));
    if ($urandom_range(0, 99) < 85) it.key = key_pool[$urandom_range(0, KeyPoolSize - 1)];
    else it.key = $urandom;
    it.value = 8'($urandom_range(0, 255));
    return it;
  endfunction

  // Present one item from the falling edge on and hold it until accepted.
  task automatic send_item(in_item_t it);
    @(negedge clk_i);
    start <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy !== 1'b0);
    apply_table_op(it);
  endtask

  // Drop start for a few cycles.
  task automatic idle_cycles(int unsigned n);
    @(negedge clk_i);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // Drop start and hold off until every queued result has shown up.
  task automatic drain_results();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic maybe_idle();
    if ($urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 3));
  endtask

  // Empty-table answers, both key extremes, update, miss paths, unused codes.
  task automatic test_directed_ops();
    send_item(make_item(OP_LOOKUP, 32'h0000_0000, 8'h00));
    send_item(make_item(OP_REMOVE, 32'h0000_0005, 8'hFF));
    send_item(make_item(OP_DUMP, 32'h0000_0000, 8'h00));
    send_item(make_item(OP_INSERT, 32'hFFFF_FFFF, 8'h00));
    send_item(make_item(OP_INSERT, 32'h0000_0000, 8'hFF));
    maybe_idle();
    send_item(make_item(OP_INSERT, 32'h8000_0000, 8'hA5));
    send_item(make_item(OP_INSERT, 32'h8000_0000, 8'h5A));
    send_item(make_item(OP_LOOKUP, 32'h0000_0000, 8'h00));
    send_item(make_item(OP_LOOKUP, 32'hFFFF_FFFF, 8'h00));
    send_item(make_item(OP_LOOKUP, 32'h7FFF_FFFF, 8'h00));
    send_item(make_item(OP_DUMP, 32'hFFFF_FFFF, 8'hFF));
    send_item(make_item(OP_REMOVE, 32'h8000_0000, 8'h00));
    maybe_idle();
    send_item(make_item(OP_REMOVE, 32'h8000_0000, 8'h00));
    send_item(make_item(OP_UNUSED_A, 32'hFFFF_FFFF, 8'hFF));
    send_item(make_item(OP_UNUSED_B, 32'h0000_0001, 8'h01));
    send_item(make_item(OP_UNUSED_C, 32'h5555_AAAA, 8'h80));
    send_item(make_item(OP_CLEAR, 32'hFFFF_FFFF, 8'hFF));
    send_item(make_item(OP_DUMP, 32'h0000_0000, 8'h00));
    drain_results();
  endtask

  // Fill in descending key order so every insert shifts the whole chain,
  // then push past capacity and dump a full table.
  task automatic test_fill_to_capacity();
    logic [31:0] key;
    int unsigned i;
    for (i = 0; i < TableDepth; i++) begin
      key = 32'hF000_0000 - (i << 24) + 32'($urandom_range(0, 32'h00FF_FFFF));
      send_item(make_item(OP_INSERT, key, 8'($urandom_range(0, 255))));
      maybe_idle();
    end
    send_item(make_item(OP_INSERT, 32'hFFFF_FFF0, 8'h11));
    send_item(make_item(OP_INSERT, key, 8'hC3));
    send_item(make_item(OP_DUMP, 32'h0000_0000, 8'h00));
    send_item(make_item(OP_REMOVE, key, 8'h00));
    send_item(make_item(OP_DUMP, 32'h0000_0000, 8'h00));
    drain_results();
  endtask

  // Random traffic with idle bursts; drain completely now and then.
  task automatic test_random_traffic(int unsigned n_items);
    int unsigned i;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h7FFF_FFFF;
    for (i = 4; i < KeyPoolSize; i++) key_pool[i] = $urandom;
    for (i = 0; i < n_items; i++) begin
      send_item(random_table_item());
      if (i % 113 == 112) drain_results();
      else maybe_idle();
    end
  endtask

  // Same traffic with start held high throughout.
  task automatic test_back_to_back(int unsigned n_items);
    int unsigned i;
    for (i = 0; i < n_items; i++) send_item(random_table_item());
    @(negedge clk_i);
    start <= 1'b0;
  endtask

  task automatic report_mismatch(string what, out_item_t want, out_item_t got);
    mismatch_count++;
    if (mismatch_count <= MaxReported) begin
      $display("%0t %s: status %0d/%0d found %0d/%0d value %0h/%0h count %0d/%0d last %0d/%0d",
               $realtime, what, want.status, got.status, want.found, got.found,
               want.value_out, got.value_out, want.entry_count, got.entry_count,
               want.last, got.last);
    end
  endtask

  // Compare every strobed result against the oldest expectation.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && result_valid_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result (exp/got)", '0, result_o);
      end else begin
        want = pending_results.pop_front();
        if (result_o.status !== want.status || result_o.found !== want.found ||
            result_o.value_out !== want.value_out ||
            result_o.entry_count !== want.entry_count || result_o.last !== want.last) begin
          report_mismatch("result mismatch (exp/got)", want, result_o);
        end
      end
    end
  end

  // Stop a hung run.
  initial begin
    #400_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    // hold reset low from the start, release on a falling edge
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    table_count = 0;

    test_directed_ops();
    test_fill_to_capacity();
    test_random_traffic(340);
    test_back_to_back(40);

    // wait out the tail, then idle on to catch any stray result
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2 * TableDepth) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sorted_key_value_table_core.f
src/skvt_pkg.sv
src/skvt_cell.sv
src/sorted_key_value_table_core.sv
dv/sorted_key_value_table_core_tb.sv
